### hdl/ang_pkg.sv
// ----------------------------------------------------------------------------
// ang_pkg
// Types, constants and log2/exp2 tables shared by the noise gate modules.
// ----------------------------------------------------------------------------
package ang_pkg;

   localparam int LOG_TABLE_BITS = 8;
   localparam int LOG_N          = 1 << LOG_TABLE_BITS;
   localparam int LOG_SH         = 23 - LOG_TABLE_BITS;
   localparam int EXP_SH         = 16 - LOG_TABLE_BITS;

   localparam logic [23:0] UNITY     = 24'h800000;
   localparam logic [16:0] COEFF_MAX = 17'd65536;
   localparam logic [25:0] DIV_M     = 26'd42949672;   // floor(2^32 / 100)
   localparam logic [6:0]  SMOOTH_N  = 7'd100;

   typedef enum logic [2:0] {
      REG_THRESHOLD = 3'd0,
      REG_RANGE     = 3'd1,
      REG_ATTACK    = 3'd2,
      REG_RELEASE   = 3'd3,
      REG_HOLD      = 3'd4,
      REG_SLOPE     = 3'd5,
      REG_HARD      = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic signed [23:0] sample_left;
      logic signed [23:0] sample_right;
   } req_type;

   typedef struct packed {
      logic signed [23:0] gated_left;
      logic signed [23:0] gated_right;
      logic               gate_is_open;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] sample_left;
      logic signed [23:0] sample_right;
      logic [23:0]        level;
   } word_type;

   typedef struct packed {
      logic [23:0] threshold_level;
      logic [23:0] range_gain;
      logic [16:0] attack_coeff;
      logic [16:0] release_coeff;
      logic [16:0] hold_length;
      logic [15:0] gate_slope;
      logic        hard_gate;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENV, ST_GATE, ST_LZ, ST_LOG, ST_MAG,
      ST_EXP, ST_SHF, ST_DIV1, ST_DIV2, ST_OUT
   } st_type;

   typedef logic [16:0] log_tab_type [0:LOG_N];
   typedef logic [31:0] exp_tab_type [0:LOG_N];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_arg;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic log_tab_type build_log_tab();
      log_tab_type t;
      logic [63:0] m;
      logic [16:0] frac;
      for (int i = 0; i < LOG_N; i++) begin
         m = 64'(LOG_N + i) << (30 - LOG_TABLE_BITS);
         frac = 17'd0;
         for (int k = 1; k <= 16; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               frac = frac | (17'd1 << (16 - k));
            end
         end
         t[i] = frac;
      end
      t[LOG_N] = COEFF_MAX;
      return t;
   endfunction

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] roots [0:LOG_TABLE_BITS];
      logic [63:0] e;
      roots[0] = 64'd2 << 30;
      for (int k = 1; k <= LOG_TABLE_BITS; k++) roots[k] = isqrt64(roots[k - 1] << 30);
      for (int i = 0; i < LOG_N; i++) begin
         e = 64'd1 << 30;
         for (int k = 0; k < LOG_TABLE_BITS; k++) begin
            if (((i >> k) & 1) == 1) begin
               e = (e * roots[LOG_TABLE_BITS - k] + (64'd1 << 29)) >> 30;
            end
         end
         t[i] = e[31:0];
      end
      t[LOG_N] = 32'h8000_0000;
      return t;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();
   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

### hdl/ang_front.sv
// ----------------------------------------------------------------------------
// ang_front
// Input stage: takes a frame, forms its peak magnitude, hands it to the queue.
// ----------------------------------------------------------------------------
module ang_front import ang_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output word_type push_data
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic [23:0] abs_l, abs_r;

   assign abs_l = req_data.sample_left[23]  ? (~req_data.sample_left + 24'd1)
                                             : req_data.sample_left;
   assign abs_r = req_data.sample_right[23] ? (~req_data.sample_right + 24'd1)
                                             : req_data.sample_right;

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_data  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (valid_ff && push_ready) valid_in = 1'b0;
      if (req_valid && req_ready) begin
         valid_in             = 1'b1;
         word_in.sample_left  = req_data.sample_left;
         word_in.sample_right = req_data.sample_right;
         word_in.level        = (abs_l > abs_r) ? abs_l : abs_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

### hdl/ang_queue.sv
// ----------------------------------------------------------------------------
// ang_queue
// Two-entry queue between the input stage and the gain engine.
// ----------------------------------------------------------------------------
module ang_queue import ang_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  word_type push_data,
   output logic     pop_valid,
   input  logic     pop,
   output word_type pop_data
);

   word_type    mem_ff [0:1];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop  ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

### hdl/ang_back.sv
// ----------------------------------------------------------------------------
// ang_back
// Gain engine: envelope, gate/hold, soft law, gain smoothing, sample scaling.
// ----------------------------------------------------------------------------
module ang_back import ang_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   output logic     q_pop,
   input  word_type q_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   function automatic logic signed [23:0] scale(input logic signed [23:0] s,
                                                input logic [23:0] g);
      logic signed [48:0] p;
      logic signed [48:0] y;
      p = s * $signed({1'b0, g});
      y = (p + 49'sd4194304) >>> 23;
      if (y > 49'sd8388607) return 24'sh7FFFFF;
      if (y < -49'sd8388608) return 24'sh800000;
      return y[23:0];
   endfunction

   st_type      state_ff, state_in;
   word_type    cur_ff, cur_in;
   logic [23:0] env_ff, env_in;
   logic [23:0] gain_ff, gain_in;
   logic [16:0] hold_ff, hold_in;
   logic        open_ff, open_in;
   logic        sel_ff, sel_in;
   logic [4:0]  p_ff, p_in;
   logic [22:0] norm_ff, norm_in;
   logic [20:0] le_ff, le_in, lt_ff, lt_in;
   logic [4:0]  qsh_ff, qsh_in;
   logic [15:0] fr_ff, fr_in;
   logic [32:0] e_ff, e_in;
   logic [23:0] tgt_ff, tgt_in;
   logic [24:0] n_ff, n_in;
   logic [18:0] qd_ff, qd_in;
   logic        rise_ff, rise_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // envelope
   logic        env_rise;
   logic [16:0] coeff_raw, coeff;
   logic [23:0] ediff;
   logic [40:0] eprod, eround;
   // gate
   logic [23:0] range_sat;
   logic        open_nx;
   logic [16:0] hold_nx;
   // log2
   logic [23:0] lx;
   logic [4:0]  lp;
   logic [23:0] lnorm;
   logic [LOG_TABLE_BITS-1:0] lidx;
   logic [LOG_TABLE_BITS:0]   lidx1;
   logic [LOG_SH-1:0]         lfrac;
   logic [16:0] llo, lhi, ld;
   logic [32:0] lprod;
   logic [20:0] lval;
   // soft law
   logic [20:0] mdiff;
   logic [36:0] mprod, msum;
   logic [16:0] earg;
   logic [LOG_TABLE_BITS-1:0] xidx;
   logic [LOG_TABLE_BITS:0]   xidx1;
   logic [EXP_SH-1:0]         xrem;
   logic [31:0] xlo, xhi, xd;
   logic [39:0] xprod;
   logic [5:0]  shamt;
   logic [33:0] gsum, gsh;
   logic [23:0] sg;
   // smoothing
   logic        srise;
   logic [23:0] sdiff;
   logic [24:0] sn;
   logic [50:0] sprod;
   logic [24:0] srem;
   logic [23:0] sstep;

   assign env_rise  = cur_ff.level > env_ff;
   assign coeff_raw = env_rise ? cfg.attack_coeff : cfg.release_coeff;
   assign coeff     = (coeff_raw > COEFF_MAX) ? COEFF_MAX : coeff_raw;
   assign ediff     = env_rise ? (cur_ff.level - env_ff) : (env_ff - cur_ff.level);
   assign eprod     = coeff * ediff;
   assign eround    = eprod + 41'd32768;

   assign range_sat = (cfg.range_gain > UNITY) ? UNITY : cfg.range_gain;

   always_comb begin
      open_nx = open_ff;
      hold_nx = hold_ff;
      priority if (env_ff >= cfg.threshold_level) begin
         open_nx = 1'b1;
         hold_nx = cfg.hold_length;
      end else if (hold_ff != 17'd0) begin
         hold_nx = hold_ff - 17'd1;
      end else begin
         open_nx = 1'b0;
      end
   end

   always_comb begin
      if (sel_ff) lx = (cfg.threshold_level == 24'd0) ? 24'd1 : cfg.threshold_level;
      else        lx = (env_ff == 24'd0) ? 24'd1 : env_ff;
      lp = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (lx[i]) lp = 5'(i);
      end
      lnorm = lx << (5'd23 - lp);
   end

   assign lidx  = norm_ff[22 -: LOG_TABLE_BITS];
   assign lidx1 = {1'b0, lidx} + 1'b1;
   assign lfrac = norm_ff[LOG_SH-1:0];
   assign llo   = LOG_TAB[{1'b0, lidx}];
   assign lhi   = LOG_TAB[lidx1];
   assign ld    = lhi - llo;
   assign lprod = ld * lfrac + (33'd1 << (LOG_SH - 1));
   assign lval  = {p_ff, 16'd0} + {4'd0, llo} + 21'(lprod >> LOG_SH);

   assign mdiff = lt_ff - le_ff;
   assign mprod = cfg.gate_slope * mdiff;
   assign msum  = mprod + 37'd32768;

   assign earg  = COEFF_MAX - {1'b0, fr_ff};
   assign xidx  = earg[15 -: LOG_TABLE_BITS];
   assign xidx1 = {1'b0, xidx} + 1'b1;
   assign xrem  = earg[EXP_SH-1:0];
   assign xlo   = EXP_TAB[{1'b0, xidx}];
   assign xhi   = EXP_TAB[xidx1];
   assign xd    = xhi - xlo;
   assign xprod = xd * xrem + (40'd1 << (EXP_SH - 1));

   always_comb begin
      shamt = 6'd8 + {1'b0, qsh_ff};
      gsum  = {1'b0, e_ff} + (34'd1 << (shamt - 6'd1));
      gsh   = gsum >> shamt;
      if (fr_ff == 16'd0)               sg = UNITY >> qsh_ff;
      else if (gsh > {10'd0, UNITY})    sg = UNITY;
      else                              sg = gsh[23:0];
   end

   assign srise = tgt_ff >= gain_ff;
   assign sdiff = srise ? (tgt_ff - gain_ff) : (gain_ff - tgt_ff);
   assign sn    = {1'b0, sdiff} + 25'd99;
   assign sprod = sn * DIV_M;
   assign srem  = n_ff - qd_ff * SMOOTH_N;
   assign sstep = (srem >= {18'd0, SMOOTH_N}) ? 24'(qd_ff + 19'd1) : {5'd0, qd_ff};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      env_in       = env_ff;
      gain_in      = gain_ff;
      hold_in      = hold_ff;
      open_in      = open_ff;
      sel_in       = sel_ff;
      p_in         = p_ff;
      norm_in      = norm_ff;
      le_in        = le_ff;
      lt_in        = lt_ff;
      qsh_in       = qsh_ff;
      fr_in        = fr_ff;
      e_in         = e_ff;
      tgt_in       = tgt_ff;
      n_in         = n_ff;
      qd_in        = qd_ff;
      rise_in      = rise_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               state_in = ST_ENV;
            end
         end
         ST_ENV: begin
            env_in   = env_rise ? (env_ff + eround[39:16]) : (env_ff - eround[39:16]);
            state_in = ST_GATE;
         end
         ST_GATE: begin
            open_in = open_nx;
            hold_in = hold_nx;
            priority if (open_nx) begin
               tgt_in   = UNITY;
               state_in = ST_DIV1;
            end else if (cfg.hard_gate) begin
               tgt_in   = range_sat;
               state_in = ST_DIV1;
            end else begin
               sel_in   = 1'b0;
               state_in = ST_LZ;
            end
         end
         ST_LZ: begin
            p_in     = lp;
            norm_in  = lnorm[22:0];
            state_in = ST_LOG;
         end
         ST_LOG: begin
            if (sel_ff) begin
               lt_in    = lval;
               state_in = ST_MAG;
            end else begin
               le_in    = lval;
               sel_in   = 1'b1;
               state_in = ST_LZ;
            end
         end
         ST_MAG: begin
            if (le_ff >= lt_ff) begin
               tgt_in   = UNITY;
               state_in = ST_DIV1;
            end else begin
               qsh_in   = msum[36:32];
               fr_in    = msum[31:16];
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            e_in     = {1'b0, xlo} + 33'(xprod >> EXP_SH);
            state_in = ST_SHF;
         end
         ST_SHF: begin
            tgt_in   = (sg > range_sat) ? sg : range_sat;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            rise_in  = srise;
            n_in     = sn;
            qd_in    = sprod[50:32];
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            gain_in  = rise_ff ? (gain_ff + sstep) : (gain_ff - sstep);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.gated_left   = scale(cur_ff.sample_left, gain_ff);
               rsp_data_in.gated_right  = scale(cur_ff.sample_right, gain_ff);
               rsp_data_in.gate_is_open = open_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= 24'd0;
         gain_ff      <= UNITY;
         hold_ff      <= 17'd0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         hold_ff      <= hold_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      sel_ff      <= sel_in;
      p_ff        <= p_in;
      norm_ff     <= norm_in;
      le_ff       <= le_in;
      lt_ff       <= lt_in;
      qsh_ff      <= qsh_in;
      fr_ff       <= fr_in;
      e_ff        <= e_in;
      tgt_ff      <= tgt_in;
      n_ff        <= n_in;
      qd_ff       <= qd_in;
      rise_ff     <= rise_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/audio_noise_gate_top.sv
// ----------------------------------------------------------------------------
// audio_noise_gate_top
// Stereo noise gate with hold, range and soft knee; register file and wiring.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    req_data   (req_type)
//   rsp      rsp_valid/rsp_ready    rsp_data   (rsp_type)
//   csr      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// The sequencer in the gain engine takes one word at a time; soft mode adds the
// log2, soft-law and, where needed, exp2 steps to those of hard or open mode.
// Synchronous reset loads register defaults, zero envelope and unity gain.
// A two-entry queue and the input stage keep accepting while the engine works,
// until they fill; a held result stalls the engine only at its final step.
// ----------------------------------------------------------------------------
module audio_noise_gate_top import ang_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;
   logic        push_valid, push_ready, q_valid, q_pop;
   word_type    push_data, q_data;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_THRESHOLD: cfg_in.threshold_level = pwdata[23:0];
            REG_RANGE:     cfg_in.range_gain      = pwdata[23:0];
            REG_ATTACK:    cfg_in.attack_coeff    = pwdata[16:0];
            REG_RELEASE:   cfg_in.release_coeff   = pwdata[16:0];
            REG_HOLD:      cfg_in.hold_length     = pwdata[16:0];
            REG_SLOPE:     cfg_in.gate_slope      = pwdata[15:0];
            REG_HARD:      cfg_in.hard_gate       = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_THRESHOLD: prdata = {8'd0, cfg_ff.threshold_level};
         REG_RANGE:     prdata = {8'd0, cfg_ff.range_gain};
         REG_ATTACK:    prdata = {15'd0, cfg_ff.attack_coeff};
         REG_RELEASE:   prdata = {15'd0, cfg_ff.release_coeff};
         REG_HOLD:      prdata = {15'd0, cfg_ff.hold_length};
         REG_SLOPE:     prdata = {16'd0, cfg_ff.gate_slope};
         REG_HARD:      prdata = {31'd0, cfg_ff.hard_gate};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_level <= 24'd83886;
         cfg_ff.range_gain      <= 24'd839;
         cfg_ff.attack_coeff    <= 17'd2675;
         cfg_ff.release_coeff   <= 17'd27;
         cfg_ff.hold_length     <= 17'd480;
         cfg_ff.gate_slope      <= 16'd58982;
         cfg_ff.hard_gate       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ang_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ang_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   ang_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
